// ===== design/mexp_pkg.sv =====
// Shared types and constants of the modular exponentiation block.
package mexp_pkg;

   // Field width of the request, response and register ports
   localparam int unsigned DATA_WIDTH = 64;

   // Register index port width and register indexes
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MODULUS          = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PUBLIC_EXPONENT  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PRIVATE_EXPONENT = 2'd2;

   // Request mode codes
   localparam logic MODE_ENCRYPT = 1'b0;
   localparam logic MODE_DECRYPT = 1'b1;

   // Sequencer states, one-hot
   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_REDUCE = 6'b000010,
      ST_STEP   = 6'b000100,
      ST_MULT   = 6'b001000,
      ST_SQUARE = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

endpackage

// ===== design/mexp_mulmod.sv =====
// Bit-serial modular multiplier: product = (a * b) mod n, one bit of b per cycle.
module mexp_mulmod #(
   parameter int unsigned WIDTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] op_a,
   input  logic [WIDTH-1:0] op_b,
   input  logic [WIDTH-1:0] modulus,
   output logic             busy,
   output logic             done,
   output logic [WIDTH-1:0] product
);

   localparam int unsigned CNT_WIDTH = $clog2(WIDTH);
   localparam int unsigned SUM_WIDTH = WIDTH + 2;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [WIDTH-1:0]     acc_ff, acc_in;
   logic [WIDTH-1:0]     a_ff, a_in;
   logic [WIDTH-1:0]     b_ff, b_in;

   logic [SUM_WIDTH-1:0] sum;
   logic [SUM_WIDTH-1:0] n_once;
   logic [SUM_WIDTH-1:0] n_twice;
   logic [SUM_WIDTH-1:0] reduced;

   // Double the accumulator, add a when the top bit of b is set, reduce below n
   always_comb begin
      n_once  = SUM_WIDTH'(modulus);
      n_twice = {1'b0, modulus, 1'b0};
      sum     = {1'b0, acc_ff, 1'b0} + (b_ff[WIDTH-1] ? SUM_WIDTH'(a_ff) : '0);
      priority if (sum >= n_twice) begin
         reduced = sum - n_twice;
      end else if (sum >= n_once) begin
         reduced = sum - n_once;
      end else begin
         reduced = sum;
      end
   end

   // Load operands on start, then advance one bit of b per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      if (busy_ff) begin
         acc_in = reduced[WIDTH-1:0];
         b_in   = {b_ff[WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_WIDTH'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_WIDTH'(WIDTH - 1);
         acc_in  = '0;
         a_in    = op_a;
         b_in    = op_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

   assign busy    = busy_ff;
   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// ===== design/modular_exponentiation.sv =====
// Top level of the modular exponentiation block (right-to-left square and multiply).
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_mode, req_value
//   rsp      out        rsp_valid / rsp_ready  rsp_result, rsp_error
//   csr      in         csr_valid / csr_ready  csr_index, csr_data
//
// Every modular multiplication runs on the shared bit-serial multiplier. A request
// first reduces the base, then for each exponent bit up to the highest set one
// does a multiply and a square for a one bit and only a square for a zero bit;
// a zero modulus or zero exponent goes straight to the finish state. One request
// is worked on at a time; the next is taken while the previous response waits in
// its output register.
// Reset is synchronous; it clears the key registers, the response valid flag and the sequencer. csr_ready is
// always high; writes are expected only while the block is idle.
module modular_exponentiation #(
   parameter int unsigned WIDTH = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_mode,
   input  logic [mexp_pkg::DATA_WIDTH-1:0]       req_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [mexp_pkg::DATA_WIDTH-1:0]       rsp_result,
   output logic                                  rsp_error,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [mexp_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [mexp_pkg::DATA_WIDTH-1:0]       csr_data
);

   mexp_pkg::state_type state_ff, state_in;

   logic [WIDTH-1:0] modulus_ff, modulus_in;
   logic [WIDTH-1:0] pub_exp_ff, pub_exp_in;
   logic [WIDTH-1:0] priv_exp_ff, priv_exp_in;

   logic [WIDTH-1:0] exp_ff, exp_in;
   logic [WIDTH-1:0] base_ff, base_in;
   logic [WIDTH-1:0] acc_ff, acc_in;
   logic             err_ff, err_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [WIDTH-1:0] rsp_result_ff, rsp_result_in;
   logic             rsp_error_ff, rsp_error_in;

   logic             mul_start;
   logic [WIDTH-1:0] mul_a;
   logic [WIDTH-1:0] mul_b;
   logic             mul_busy;
   logic             mul_done;
   logic [WIDTH-1:0] mul_product;

   logic [WIDTH-1:0] exp_sel;
   logic [WIDTH-1:0] one_mod;
   logic             req_fire;

   assign req_ready = (state_ff == mexp_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign exp_sel = (req_mode == mexp_pkg::MODE_DECRYPT) ? priv_exp_ff : pub_exp_ff;
   assign one_mod = (modulus_ff == WIDTH'(1)) ? '0 : WIDTH'(1);

   // Write key registers, keep only the low WIDTH bits
   always_comb begin
      modulus_in  = modulus_ff;
      pub_exp_in  = pub_exp_ff;
      priv_exp_in = priv_exp_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            mexp_pkg::CSR_MODULUS:          modulus_in  = csr_data[WIDTH-1:0];
            mexp_pkg::CSR_PUBLIC_EXPONENT:  pub_exp_in  = csr_data[WIDTH-1:0];
            mexp_pkg::CSR_PRIVATE_EXPONENT: priv_exp_in = csr_data[WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Sequence reduction, multiplies and squarings over the exponent bits
   always_comb begin
      state_in      = state_ff;
      exp_in        = exp_ff;
      base_in       = base_ff;
      acc_in        = acc_ff;
      err_in        = err_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_result_in = rsp_result_ff;
      rsp_error_in  = rsp_error_ff;
      mul_start     = 1'b0;
      mul_a         = base_ff;
      mul_b         = base_ff;

      unique case (state_ff)
         mexp_pkg::ST_IDLE: begin
            if (req_fire) begin
               exp_in  = exp_sel;
               base_in = req_value[WIDTH-1:0];
               acc_in  = one_mod;
               err_in  = 1'b0;
               if (modulus_ff == '0) begin
                  acc_in   = '0;
                  err_in   = 1'b1;
                  state_in = mexp_pkg::ST_FINISH;
               end else if (exp_sel == '0) begin
                  acc_in   = WIDTH'(1);
                  state_in = mexp_pkg::ST_FINISH;
               end else begin
                  // Reduce the base as base * 1 mod n
                  mul_start = 1'b1;
                  mul_a     = one_mod;
                  mul_b     = req_value[WIDTH-1:0];
                  state_in  = mexp_pkg::ST_REDUCE;
               end
            end
         end
         mexp_pkg::ST_REDUCE: begin
            if (mul_done) begin
               base_in  = mul_product;
               state_in = mexp_pkg::ST_STEP;
            end
         end
         mexp_pkg::ST_STEP: begin
            if (exp_ff == '0) begin
               state_in = mexp_pkg::ST_FINISH;
            end else if (exp_ff[0]) begin
               mul_start = 1'b1;
               mul_a     = acc_ff;
               mul_b     = base_ff;
               state_in  = mexp_pkg::ST_MULT;
            end else begin
               mul_start = 1'b1;
               state_in  = mexp_pkg::ST_SQUARE;
            end
         end
         mexp_pkg::ST_MULT: begin
            if (mul_done) begin
               acc_in    = mul_product;
               mul_start = 1'b1;
               state_in  = mexp_pkg::ST_SQUARE;
            end
         end
         mexp_pkg::ST_SQUARE: begin
            if (mul_done) begin
               base_in  = mul_product;
               exp_in   = {1'b0, exp_ff[WIDTH-1:1]};
               state_in = mexp_pkg::ST_STEP;
            end
         end
         mexp_pkg::ST_FINISH: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_result_in = acc_ff;
               rsp_error_in  = err_ff;
               state_in      = mexp_pkg::ST_IDLE;
            end
         end
         default: state_in = mexp_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mexp_pkg::ST_IDLE;
         modulus_ff   <= '0;
         pub_exp_ff   <= '0;
         priv_exp_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         modulus_ff   <= modulus_in;
         pub_exp_ff   <= pub_exp_in;
         priv_exp_ff  <= priv_exp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      exp_ff        <= exp_in;
      base_ff       <= base_in;
      acc_ff        <= acc_in;
      err_ff        <= err_in;
      rsp_result_ff <= rsp_result_in;
      rsp_error_ff  <= rsp_error_in;
   end

   // Shared bit-serial modular multiplier; start is issued only when it is free
   mexp_mulmod #(
      .WIDTH(WIDTH)
   ) u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start && !mul_busy),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .modulus (modulus_ff),
      .busy    (mul_busy),
      .done    (mul_done),
      .product (mul_product)
   );

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = mexp_pkg::DATA_WIDTH'(rsp_result_ff);
   assign rsp_error  = rsp_error_ff;

endmodule

// ===== dv/tb_modular_exponentiation.sv =====
// Self-checking testbench for the modular exponentiation block.
module tb_modular_exponentiation;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned DW              = mexp_pkg::DATA_WIDTH;
   localparam int unsigned OP_WIDTH        = 64;
   localparam int unsigned CLOCK_PERIOD    = 20;
   localparam int unsigned RESET_CYCLES    = 9;
   localparam int unsigned SETTLE_CYCLES   = 4 * (OP_WIDTH + 2);
   localparam int unsigned WATCHDOG_LIMIT  = 40000;
   localparam int unsigned RANDOM_PHASES   = 6;
   localparam int unsigned PHASE_REQUESTS  = 13;
   localparam logic [DW-1:0] ALL_ONES      = {DW{1'b1}};
   localparam logic [DW-1:0] OP_MASK       = ALL_ONES >> (DW - OP_WIDTH);
   // Index past the last register; writes to it must change nothing
   localparam logic [mexp_pkg::CSR_INDEX_WIDTH-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [DW-1:0] result;
      logic          error;
   } residue_type;

   // Expected residues, computed from a private copy of the key registers
   class residue_scoreboard_type;
      logic [DW-1:0] key_n;
      logic [DW-1:0] key_e;
      logic [DW-1:0] key_d;
      residue_type   expected_residues[$];
      int unsigned   mismatches;
      int unsigned   checked;
      int unsigned   error_responses;

      function new();
         key_n = '0;
         key_e = '0;
         key_d = '0;
         mismatches = 0;
         checked = 0;
         error_responses = 0;
      endfunction

      function void write_register(logic [mexp_pkg::CSR_INDEX_WIDTH-1:0] index,
                                   logic [DW-1:0] data);
         case (index)
            mexp_pkg::CSR_MODULUS:          key_n = data;
            mexp_pkg::CSR_PUBLIC_EXPONENT:  key_e = data;
            mexp_pkg::CSR_PRIVATE_EXPONENT: key_d = data;
            default: ;
         endcase
      endfunction

      // Exact (a * b) mod n through a double-width product
      static function logic [DW-1:0] mod_product(logic [DW-1:0] a, logic [DW-1:0] b,
                                                 logic [DW-1:0] n);
         logic [2*DW-1:0] wide;
         wide = {{DW{1'b0}}, a} * {{DW{1'b0}}, b};
         wide = wide % {{DW{1'b0}}, n};
         return wide[DW-1:0];
      endfunction

      // Right-to-left square and multiply over the operand width
      static function logic [DW-1:0] mod_power(logic [DW-1:0] base, logic [DW-1:0] exponent,
                                               logic [DW-1:0] n);
         logic [DW-1:0] acc;
         logic [DW-1:0] power;
         power = base % n;
         acc = DW'(1) % n;
         for (int i = 0; i < OP_WIDTH; i++) begin
            if (exponent[i]) begin
               acc = mod_product(acc, power, n);
            end
            power = mod_product(power, power, n);
         end
         return acc;
      endfunction

      function int unsigned pending();
         return expected_residues.size();
      endfunction

      function void note_request(logic mode, logic [DW-1:0] value);
         residue_type   r;
         logic [DW-1:0] n;
         logic [DW-1:0] e;
         n = key_n & OP_MASK;
         e = ((mode == mexp_pkg::MODE_DECRYPT) ? key_d : key_e) & OP_MASK;
         // Zero modulus wins over zero exponent
         if (n == '0) begin
            r.result = '0;
            r.error  = 1'b1;
         end else if (e == '0) begin
            r.result = DW'(1);
            r.error  = 1'b0;
         end else begin
            r.result = mod_power(value & OP_MASK, e, n);
            r.error  = 1'b0;
         end
         expected_residues.push_back(r);
      endfunction

      task report_mismatch(string what);
         $display("[%0t] MISMATCH: %s", $realtime, what);
         mismatches++;
      endtask

      task check_response(logic [DW-1:0] result, logic error);
         residue_type r;
         if (expected_residues.size() == 0) begin
            report_mismatch($sformatf("response result=%h error=%b with no request pending",
                                      result, error));
            return;
         end
         r = expected_residues.pop_front();
         checked++;
         if (r.error) begin
            error_responses++;
         end
         if (result !== r.result) begin
            report_mismatch($sformatf("result %h, expected %h", result, r.result));
         end
         if (error !== r.error) begin
            report_mismatch($sformatf("error %b, expected %b", error, r.error));
         end
      endtask
   endclass

   logic                                 clock      = 1'b0;
   logic                                 reset      = 1'b1;
   logic                                 req_valid  = 1'b0;
   logic                                 req_ready;
   logic                                 req_mode   = mexp_pkg::MODE_ENCRYPT;
   logic [DW-1:0]                        req_value  = '0;
   logic                                 rsp_valid;
   logic                                 rsp_ready  = 1'b0;
   logic [DW-1:0]                        rsp_result;
   logic                                 rsp_error;
   logic                                 csr_valid  = 1'b0;
   logic                                 csr_ready;
   logic [mexp_pkg::CSR_INDEX_WIDTH-1:0] csr_index  = mexp_pkg::CSR_MODULUS;
   logic [DW-1:0]                        csr_data   = '0;

   residue_scoreboard_type ledger = new();

   int unsigned quiet_cycles    = 0;
   int unsigned requests_sent   = 0;
   int unsigned key_settings    = 0;
   int unsigned burst_left      = 0;
   int unsigned stall_left      = 0;
   int unsigned stall_kind      = 0;
   int unsigned stall_tick      = 0;

   modular_exponentiation #(
      .WIDTH(OP_WIDTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_mode   (req_mode),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_result (rsp_result),
      .rsp_error  (rsp_error),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Receiver: alternate between always ready, coin flips, long stalls and a sparse pattern
   always @(posedge clock) begin
      stall_tick <= stall_tick + 1;
      if (stall_left == 0) begin
         stall_kind <= $urandom_range(0, 3);
         stall_left <= $urandom_range(1, 400);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_kind)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= 1'b0;
         default: rsp_ready <= (stall_tick % 4 == 0);
      endcase
   end

   // Check every accepted response
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         ledger.check_response(rsp_result, rsp_error);
      end
   end

   // Count cycles without any handshake
   always @(posedge clock) begin
      if ((req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready) ||
          (csr_valid && csr_ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("watchdog: no handshake for %0d cycles, %0d responses outstanding",
               quiet_cycles, ledger.pending());
      $display("tb_modular_exponentiation: done, errors");
      $finish;
   end

   function automatic logic [DW-1:0] random_word();
      return {$urandom(), $urandom()};
   endfunction

   // Random value with exactly len significant bits
   function automatic logic [DW-1:0] random_bits(int unsigned len);
      logic [DW-1:0] w;
      w = random_word();
      if (len == 0) begin
         return '0;
      end
      if (len < DW) begin
         w = w & ((64'd1 << len) - 1);
      end
      w[len-1] = 1'b1;
      return w;
   endfunction

   // Drop valid and hold until every expected response has come back
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (ledger.pending() != 0);
   endtask

   task automatic write_register(logic [mexp_pkg::CSR_INDEX_WIDTH-1:0] index,
                                 logic [DW-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      ledger.write_register(index, data);
   endtask

   // Load a full key while idle; also poke the unused index
   task automatic configure_key(logic [DW-1:0] n, logic [DW-1:0] e, logic [DW-1:0] d);
      write_register(CSR_UNUSED, random_word());
      write_register(mexp_pkg::CSR_MODULUS, n);
      write_register(mexp_pkg::CSR_PUBLIC_EXPONENT, e);
      write_register(mexp_pkg::CSR_PRIVATE_EXPONENT, d);
      csr_valid <= 1'b0;
      key_settings++;
   endtask

   // Send one request, pacing the sender in bursts with gaps between them
   task automatic send_request(logic mode, logic [DW-1:0] value);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 10);
         if ($urandom_range(0, 11) == 0) begin
            hold_until_drained();
         end else begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 600)
                                              : $urandom_range(0, 6);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_mode  <= mode;
      req_value <= value;
      do @(posedge clock); while (req_ready !== 1'b1);
      ledger.note_request(mode, value);
      requests_sent++;
   endtask

   function automatic logic random_mode();
      return $urandom_range(0, 1) ? mexp_pkg::MODE_DECRYPT : mexp_pkg::MODE_ENCRYPT;
   endfunction

   initial begin
      logic [DW-1:0] n;
      logic [DW-1:0] e;
      logic [DW-1:0] d;
      logic [DW-1:0] v;
      int unsigned   pick;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Zero modulus right after reset, then with nonzero exponents: always an error
      send_request(mexp_pkg::MODE_ENCRYPT, 64'd5);
      send_request(mexp_pkg::MODE_DECRYPT, ALL_ONES);
      hold_until_drained();
      configure_key('0, 64'h10001, 64'd3);
      send_request(mexp_pkg::MODE_ENCRYPT, 64'd7);
      send_request(mexp_pkg::MODE_DECRYPT, '0);

      // Modulus of one: zero exponent stays 1, any other exponent gives 0
      hold_until_drained();
      configure_key(64'd1, '0, 64'd5);
      send_request(mexp_pkg::MODE_ENCRYPT, 64'd9);
      send_request(mexp_pkg::MODE_DECRYPT, 64'd7);

      // Small textbook key: round trip, edge bases and bases above the modulus
      hold_until_drained();
      configure_key(64'd3233, 64'd17, 64'd2753);
      send_request(mexp_pkg::MODE_ENCRYPT, 64'd65);
      send_request(mexp_pkg::MODE_DECRYPT, 64'd2790);
      send_request(mexp_pkg::MODE_ENCRYPT, '0);
      send_request(mexp_pkg::MODE_DECRYPT, 64'd1);
      send_request(mexp_pkg::MODE_ENCRYPT, 64'd3232);
      send_request(mexp_pkg::MODE_DECRYPT, 64'd3233);
      send_request(mexp_pkg::MODE_ENCRYPT, ALL_ONES);

      // Widest modulus with a full-width exponent and an exponent of one
      hold_until_drained();
      configure_key(ALL_ONES, ALL_ONES, 64'd1);
      send_request(mexp_pkg::MODE_ENCRYPT, ALL_ONES);
      send_request(mexp_pkg::MODE_ENCRYPT, 64'd2);
      send_request(mexp_pkg::MODE_DECRYPT, ALL_ONES - 1);
      send_request(mexp_pkg::MODE_DECRYPT, random_word());

      // Power-of-two modulus, zero private exponent
      hold_until_drained();
      configure_key(64'h8000_0000_0000_0000, 64'd2, '0);
      send_request(mexp_pkg::MODE_ENCRYPT, ALL_ONES);
      send_request(mexp_pkg::MODE_ENCRYPT, 64'h8000_0000_0000_0005);
      send_request(mexp_pkg::MODE_DECRYPT, random_word());

      // Random keys; most bases below the modulus, some arbitrary or at the edges
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         pick = $urandom_range(0, 9);
         n = (pick == 0) ? '0 :
             (pick == 1) ? 64'd1 :
             (pick == 2) ? ALL_ONES : (random_bits($urandom_range(2, 64)) | 64'd1);
         e = (p == 3) ? random_bits(64) :
             ($urandom_range(0, 7) == 0) ? '0 : random_bits($urandom_range(1, 16));
         d = (p == 5) ? random_bits(64) :
             ($urandom_range(0, 7) == 0) ? '0 : random_bits($urandom_range(1, 24));
         hold_until_drained();
         configure_key(n, e, d);
         for (int k = 0; k < PHASE_REQUESTS; k++) begin
            pick = $urandom_range(0, 7);
            case (pick)
               0: v = random_word();
               1: v = (pick == 1 && $urandom_range(0, 1)) ? ALL_ONES : '0;
               2: v = n - 1;
               default: v = (n == '0) ? random_word() : random_word() % n;
            endcase
            send_request(random_mode(), v);
         end
      end

      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (ledger.pending() != 0) begin
         ledger.report_mismatch($sformatf("%0d responses never arrived", ledger.pending()));
      end

      $display("covered %0d requests under %0d key settings, %0d with zero modulus",
               requests_sent, key_settings, ledger.error_responses);
      $display("%0d responses checked, %0d mismatches", ledger.checked, ledger.mismatches);
      if (ledger.mismatches == 0) begin
         $display("tb_modular_exponentiation: done, clean");
      end else begin
         $display("tb_modular_exponentiation: done, errors");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/mexp_pkg.sv
design/mexp_mulmod.sv
design/modular_exponentiation.sv
dv/tb_modular_exponentiation.sv
